// ===== design/lsbc_pkg.sv =====
// Shared types and constants of the sector block cache core.
// Every design file imports this package; it depends on nothing else.
package lsbc_pkg;

   localparam int SECTORS_PER_BLOCK = 64;
   localparam int MAX_REQUEST       = 1024;

   localparam int SECTOR_W    = 32;
   localparam int STAMP_W     = 32;
   localparam int OFF_W       = $clog2(SECTORS_PER_BLOCK);
   localparam int LEN_W       = $clog2(SECTORS_PER_BLOCK + 1);
   localparam int LEFT_W      = 11;
   localparam int SUM_W       = LEFT_W + 1;
   localparam int SLOT_OUT_W  = 4;
   localparam int SLOTS_CFG_W = 5;

   localparam logic [SLOTS_CFG_W-1:0] SLOTS_CFG_RESET = SLOTS_CFG_W'(16);
   localparam logic [LEFT_W-1:0]      MAX_REQUEST_L   = LEFT_W'(MAX_REQUEST);
   localparam logic [LEN_W-1:0]       BLOCK_LEN       = LEN_W'(SECTORS_PER_BLOCK);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } seq_state_type;

   // Write-back of one slot after a chunk has been resolved.
   typedef struct packed {
      logic                en;
      logic [SECTOR_W-1:0] tag;
      logic [STAMP_W-1:0]  stamp;
   } slot_wr_type;

endpackage

// ===== design/lsbc_mem.sv =====
// Slot storage: block tag memory and use stamp memory, both with registered read data.
// Stamps of slots never written read as zero through per-slot valid bits. Uses lsbc_pkg.
module lsbc_mem
   import lsbc_pkg::*;
#(
   parameter int SLOT_COUNT = 16,
   localparam int IDX_W = $clog2(SLOT_COUNT)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   input  logic [IDX_W-1:0]    wr_addr,
   input  slot_wr_type         wr,
   output logic [SECTOR_W-1:0] tag_rd,
   output logic [STAMP_W-1:0]  stamp_rd
);

   logic [SECTOR_W-1:0] tag_mem [SLOT_COUNT];
   logic [STAMP_W-1:0]  stamp_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] stamp_vld_ff;

   logic [SECTOR_W-1:0] tag_q_ff;
   logic [STAMP_W-1:0]  stamp_q_ff;
   logic                vld_q_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         tag_mem[wr_addr]   <= wr.tag;
         stamp_mem[wr_addr] <= wr.stamp;
      end
      if (rd_en) begin
         tag_q_ff   <= tag_mem[rd_addr];
         stamp_q_ff <= stamp_mem[rd_addr];
         vld_q_ff   <= stamp_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_vld_ff <= '0;
      end else if (wr.en) begin
         stamp_vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign tag_rd   = tag_q_ff;
   assign stamp_rd = vld_q_ff ? stamp_q_ff : '0;

endmodule

// ===== design/lsbc_seq.sv =====
// Request sequencer: splits a request into block chunks, scans the slot memories
// for a tag hit and a victim, writes the slot back and registers one result per chunk.
// Uses lsbc_pkg.
module lsbc_seq
   import lsbc_pkg::*;
#(
   parameter int SLOT_COUNT = 16,
   localparam int IDX_W = $clog2(SLOT_COUNT),
   localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SLOTS_CFG_W-1:0] slots_cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_operation,
   input  logic [SECTOR_W-1:0]    req_start_sector,
   input  logic [LEFT_W-1:0]      req_sector_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SLOT_OUT_W-1:0]  rsp_slot,
   output logic                   rsp_miss,
   output logic [SECTOR_W-1:0]    rsp_block_base,
   output logic [OFF_W-1:0]       rsp_offset_in_block,
   output logic [LEN_W-1:0]       rsp_chunk_length,
   output logic                   rsp_is_write,
   output logic                   rsp_last,
   output logic                   mem_rd_en,
   output logic [IDX_W-1:0]       mem_rd_addr,
   output logic [IDX_W-1:0]       mem_wr_addr,
   output slot_wr_type            mem_wr,
   input  logic [SECTOR_W-1:0]    mem_tag_rd,
   input  logic [STAMP_W-1:0]     mem_stamp_rd
);

   seq_state_type state_ff, state_in;
   logic                op_ff, op_in;
   logic [SECTOR_W-1:0] sector_ff, sector_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   logic [STAMP_W-1:0]  access_ff, access_in;
   logic [CNT_W-1:0]    alloc_ff, alloc_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [STAMP_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]    vic_idx_ff, vic_idx_in;
   logic                vic_done_ff, vic_done_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic                  rsp_miss_ff;
   logic [SECTOR_W-1:0]   rsp_base_ff;
   logic [OFF_W-1:0]      rsp_off_ff;
   logic [LEN_W-1:0]      rsp_len_ff;
   logic                  rsp_wr_ff;
   logic                  rsp_last_ff;

   logic [CNT_W-1:0]    lim;
   logic [CNT_W:0]      alloc_plus;
   logic [CNT_W-1:0]    alloc_new;
   logic [CNT_W-1:0]    scan_range;
   logic                issue;
   logic [CNT_W-1:0]    pend_cnt;
   logic [SECTOR_W-1:0] base;
   logic [OFF_W-1:0]    off;
   logic [SUM_W-1:0]    end_sum;
   logic [LEN_W-1:0]    len;
   logic [LEFT_W-1:0]   left_rem;
   logic                out_free;
   logic [IDX_W-1:0]    slot_sel;
   logic [STAMP_W-1:0]  access_inc;
   logic                emit_go;

   always_comb begin
      if (slots_cfg == '0) begin
         lim = CNT_W'(1);
      end else if (32'(slots_cfg) > 32'(SLOT_COUNT)) begin
         lim = CNT_W'(SLOT_COUNT);
      end else begin
         lim = CNT_W'(slots_cfg);
      end
   end

   // Slot count after an allocation; the scan covers both the allocated
   // slots (tag lookup) and the candidates for a victim.
   assign alloc_plus = {1'b0, alloc_ff} + (CNT_W + 1)'(1);
   assign alloc_new  = (alloc_plus > {1'b0, lim}) ? lim : alloc_plus[CNT_W-1:0];
   assign scan_range = (alloc_ff > alloc_new) ? alloc_ff : alloc_new;

   assign issue    = (state_ff == ST_SCAN) && (idx_ff < scan_range);
   assign pend_cnt = CNT_W'(pend_idx_ff);

   assign base     = {sector_ff[SECTOR_W-1:OFF_W], OFF_W'(0)};
   assign off      = sector_ff[OFF_W-1:0];
   assign end_sum  = SUM_W'(off) + SUM_W'(left_ff);
   assign len      = (end_sum > SUM_W'(SECTORS_PER_BLOCK)) ? (BLOCK_LEN - LEN_W'(off))
                                                          : left_ff[LEN_W-1:0];
   assign left_rem = left_ff - LEFT_W'(len);

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign slot_sel   = hit_ff ? hit_idx_ff : vic_idx_ff;
   assign access_inc = access_ff + STAMP_W'(1);
   assign emit_go    = (state_ff == ST_EMIT) && out_free;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sector_in    = sector_ff;
      left_in      = left_ff;
      access_in    = access_ff;
      alloc_in     = alloc_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      best_in      = best_ff;
      vic_idx_in   = vic_idx_ff;
      vic_done_in  = vic_done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               access_in = access_inc;
               op_in     = req_operation;
               sector_in = req_start_sector;
               left_in   = (req_sector_count > MAX_REQUEST_L) ? MAX_REQUEST_L
                                                              : req_sector_count;
               if (left_in != '0) begin
                  state_in    = ST_SCAN;
                  idx_in      = '0;
                  hit_in      = 1'b0;
                  vic_done_in = 1'b0;
                  vic_idx_in  = '0;
                  best_in     = access_inc;
               end
            end
         end
         ST_SCAN: begin
            pend_in     = issue;
            pend_idx_in = idx_ff[IDX_W-1:0];
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (!hit_ff && (pend_cnt < alloc_ff) && (mem_tag_rd == base)) begin
                  hit_in     = 1'b1;
                  hit_idx_in = pend_idx_ff;
               end
               // Oldest stamp wins, later slots on ties; a zero stamp ends the search.
               if (!vic_done_ff && (pend_cnt < alloc_new) && (mem_stamp_rd <= best_ff)) begin
                  best_in    = mem_stamp_rd;
                  vic_idx_in = pend_idx_ff;
                  if (mem_stamp_rd == '0) begin
                     vic_done_in = 1'b1;
                  end
               end
            end
            if (!issue && !pend_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               alloc_in     = hit_ff ? alloc_ff : alloc_new;
               left_in      = left_rem;
               if (left_rem != '0) begin
                  sector_in   = sector_ff + SECTOR_W'(len);
                  access_in   = access_inc;
                  state_in    = ST_SCAN;
                  idx_in      = '0;
                  hit_in      = 1'b0;
                  vic_done_in = 1'b0;
                  vic_idx_in  = '0;
                  best_in     = access_inc;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         access_ff    <= '0;
         alloc_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         access_ff    <= access_in;
         alloc_ff     <= alloc_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      sector_ff   <= sector_in;
      left_ff     <= left_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      best_ff     <= best_in;
      vic_idx_ff  <= vic_idx_in;
      vic_done_ff <= vic_done_in;
      if (emit_go) begin
         rsp_slot_ff <= SLOT_OUT_W'(slot_sel);
         rsp_miss_ff <= !hit_ff;
         rsp_base_ff <= base;
         rsp_off_ff  <= off;
         rsp_len_ff  <= len;
         rsp_wr_ff   <= op_ff;
         rsp_last_ff <= (left_rem == '0);
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign mem_rd_en   = issue;
   assign mem_rd_addr = idx_ff[IDX_W-1:0];
   assign mem_wr_addr = slot_sel;
   assign mem_wr.en    = emit_go;
   assign mem_wr.tag   = base;
   assign mem_wr.stamp = access_ff;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_miss            = rsp_miss_ff;
   assign rsp_block_base      = rsp_base_ff;
   assign rsp_offset_in_block = rsp_off_ff;
   assign rsp_chunk_length    = rsp_len_ff;
   assign rsp_is_write        = rsp_wr_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// ===== design/lru_sector_block_cache_core.sv =====
// Top level of the sector block cache core: slot-count register, sequencer and slot memories.
// Depends on lsbc_pkg, lsbc_mem and lsbc_seq.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  operation, start_sector, sector_count
//   rsp      out        rsp_valid/rsp_stall  slot, miss, block_base, offset, length, write, last
//   csr      in         csr_valid/csr_ready  slots_in_use
//
// A request is taken while the sequencer is idle; for each of its chunks the sequencer then reads
// the tag and stamp memories once per scanned slot (at most SLOT_COUNT slots), waits for the
// registered read data, closes the scan, and then writes the slot back and registers the result.
// req_stall is high from acceptance of a non-empty request until its last chunk is in the result register.
// A stalled result holds the sequencer in its write-back step; the next request is still taken
// while the last result waits. Reset is synchronous and clears the stamp valid bits, counters and valids.
module lru_sector_block_cache_core
   import lsbc_pkg::*;
#(
   parameter int SLOT_COUNT = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_operation,
   input  logic [SECTOR_W-1:0]    req_start_sector,
   input  logic [LEFT_W-1:0]      req_sector_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SLOT_OUT_W-1:0]  rsp_slot,
   output logic                   rsp_miss,
   output logic [SECTOR_W-1:0]    rsp_block_base,
   output logic [OFF_W-1:0]       rsp_offset_in_block,
   output logic [LEN_W-1:0]       rsp_chunk_length,
   output logic                   rsp_is_write,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [SLOTS_CFG_W-1:0] csr_slots_in_use
);

   localparam int IDX_W = $clog2(SLOT_COUNT);

   logic [SLOTS_CFG_W-1:0] slots_cfg_ff;
   logic [SLOTS_CFG_W-1:0] slots_cfg_in;

   logic                mem_rd_en;
   logic [IDX_W-1:0]    mem_rd_addr;
   logic [IDX_W-1:0]    mem_wr_addr;
   slot_wr_type         mem_wr;
   logic [SECTOR_W-1:0] mem_tag_rd;
   logic [STAMP_W-1:0]  mem_stamp_rd;

   assign csr_ready    = 1'b1;
   assign slots_cfg_in = (csr_valid && csr_ready) ? csr_slots_in_use : slots_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_cfg_ff <= SLOTS_CFG_RESET;
      end else begin
         slots_cfg_ff <= slots_cfg_in;
      end
   end

   lsbc_seq #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_seq (
      .clock               (clock),
      .reset               (reset),
      .slots_cfg           (slots_cfg_ff),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_start_sector    (req_start_sector),
      .req_sector_count    (req_sector_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_slot            (rsp_slot),
      .rsp_miss            (rsp_miss),
      .rsp_block_base      (rsp_block_base),
      .rsp_offset_in_block (rsp_offset_in_block),
      .rsp_chunk_length    (rsp_chunk_length),
      .rsp_is_write        (rsp_is_write),
      .rsp_last            (rsp_last),
      .mem_rd_en           (mem_rd_en),
      .mem_rd_addr         (mem_rd_addr),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr              (mem_wr),
      .mem_tag_rd          (mem_tag_rd),
      .mem_stamp_rd        (mem_stamp_rd)
   );

   lsbc_mem #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .wr_addr  (mem_wr_addr),
      .wr       (mem_wr),
      .tag_rd   (mem_tag_rd),
      .stamp_rd (mem_stamp_rd)
   );

endmodule

// ===== design/lsbc_checker.sv =====
// Port-level checker for the sector block cache core, bound to its top level.
// Depends on lsbc_pkg.
module lsbc_checker
   import lsbc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic [LEFT_W-1:0]     req_sector_count,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [SLOT_OUT_W-1:0] rsp_slot,
   input logic [SECTOR_W-1:0]   rsp_block_base,
   input logic [OFF_W-1:0]      rsp_offset_in_block,
   input logic [LEN_W-1:0]      rsp_chunk_length,
   input logic                  rsp_last
);

   // A result that is not taken stays presented unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_block_base)
         && $stable(rsp_chunk_length) && $stable(rsp_last))
   else $error("stalled result changed or dropped");

   // No chunk crosses a block boundary, and none is empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chunk_length != '0)
         && (LEN_W'(rsp_offset_in_block) + rsp_chunk_length <= BLOCK_LEN))
   else $error("chunk leaves its block");

   // Every chunk but the last of a request runs to the end of its block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (LEN_W'(rsp_offset_in_block) + rsp_chunk_length == BLOCK_LEN))
   else $error("inner chunk stops short of the block end");

   // Once a non-empty request is taken, no further request is taken next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_sector_count != '0) |=> req_stall)
   else $error("request taken while another is in progress");

endmodule

bind lru_sector_block_cache_core lsbc_checker u_lsbc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_sector_count    (req_sector_count),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_slot            (rsp_slot),
   .rsp_block_base      (rsp_block_base),
   .rsp_offset_in_block (rsp_offset_in_block),
   .rsp_chunk_length    (rsp_chunk_length),
   .rsp_last            (rsp_last)
);

// ===== bench/tb_lru_sector_block_cache_core.sv =====
// Self-checking bench for lru_sector_block_cache_core: splits sector requests into block chunks
// in its own model of the LRU slot cache and checks every chunk result. Needs lsbc_pkg and the core.
module tb_lru_sector_block_cache_core;
   timeunit 1ns;
   timeprecision 1ps;
   import lsbc_pkg::*;

   localparam int SLOTS         = 16;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_AT       = 30;
   localparam int LONG_HOLD     = 300;

   typedef struct {
      logic                op;
      logic [SECTOR_W-1:0] start;
      logic [LEFT_W-1:0]   count;
   } request_type;

   typedef struct {
      logic [SLOT_OUT_W-1:0] slot;
      logic                  miss;
      logic [SECTOR_W-1:0]   base;
      logic [OFF_W-1:0]      offset;
      logic [LEN_W-1:0]      length;
      logic                  is_write;
      logic                  last;
   } chunk_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_operation = 1'b0;
   logic [SECTOR_W-1:0]    req_start_sector = '0;
   logic [LEFT_W-1:0]      req_sector_count = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SLOT_OUT_W-1:0]  rsp_slot;
   logic                   rsp_miss;
   logic [SECTOR_W-1:0]    rsp_block_base;
   logic [OFF_W-1:0]       rsp_offset_in_block;
   logic [LEN_W-1:0]       rsp_chunk_length;
   logic                   rsp_is_write;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [SLOTS_CFG_W-1:0] csr_slots_in_use = '0;

   // Cache model state, mirrored from the block's point of view.
   logic [SECTOR_W-1:0]    tag_mem [SLOTS];
   logic [STAMP_W-1:0]     stamp_mem [SLOTS];
   int unsigned            alloc_cnt;
   logic [STAMP_W-1:0]     access_cnt;
   logic [SLOTS_CFG_W-1:0] slot_limit;

   request_type request_fifo [$];
   chunk_type   chunk_fifo [$];
   int       req_queued = 0;
   int       req_taken = 0;
   int       sender_gap = 0;
   int       stall_run = 0;
   bit       hold_done = 1'b0;
   int       mismatches = 0;
   int       chunks_checked = 0;
   int       misses_seen = 0;
   int       limits_used = 1;

   lru_sector_block_cache_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_start_sector    (req_start_sector),
      .req_sector_count    (req_sector_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_slot            (rsp_slot),
      .rsp_miss            (rsp_miss),
      .rsp_block_base      (rsp_block_base),
      .rsp_offset_in_block (rsp_offset_in_block),
      .rsp_chunk_length    (rsp_chunk_length),
      .rsp_is_write        (rsp_is_write),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_slots_in_use    (csr_slots_in_use)
   );

   always #5 clock = ~clock;

   // Cuts one request into block chunks, allocating and stamping slots as the cache does.
   function automatic void split_request(input logic op, input logic [SECTOR_W-1:0] start,
                                         input logic [LEFT_W-1:0] count);
      logic [SECTOR_W-1:0] sector;
      logic [SECTOR_W-1:0] base;
      logic [STAMP_W-1:0]  best;
      int unsigned         left;
      int unsigned         off;
      int unsigned         len;
      int unsigned         lim;
      int unsigned         slot;
      int                  hit;
      chunk_type           c;
      sector = start;
      left = 32'((count > MAX_REQUEST_L) ? MAX_REQUEST_L : count);
      access_cnt++;
      while (left > 0) begin
         base = sector - (sector % SECTOR_W'(SECTORS_PER_BLOCK));
         off = sector - base;
         hit = -1;
         for (int i = 0; i < alloc_cnt && i < SLOTS; i++) begin
            if (hit < 0 && tag_mem[i] == base) hit = i;
         end
         c.miss = (hit < 0);
         if (hit < 0) begin
            // Victim: the oldest stamp, later slots winning ties, stopping at a never-used slot.
            lim = (slot_limit == 0) ? 1 : (slot_limit > SLOTS) ? SLOTS : 32'(slot_limit);
            alloc_cnt++;
            if (alloc_cnt > lim) alloc_cnt = lim;
            best = access_cnt;
            slot = 0;
            for (int i = 0; i < alloc_cnt && i < SLOTS; i++) begin
               if (stamp_mem[i] <= best) begin
                  best = stamp_mem[i];
                  slot = i;
                  if (best == 0) break;
               end
            end
         end else begin
            slot = hit;
         end
         tag_mem[slot] = base;
         stamp_mem[slot] = access_cnt;
         len = (off + left > SECTORS_PER_BLOCK) ? SECTORS_PER_BLOCK - off : left;
         left -= len;
         c.slot = SLOT_OUT_W'(slot);
         c.base = base;
         c.offset = OFF_W'(off);
         c.length = LEN_W'(len);
         c.is_write = op;
         c.last = (left == 0);
         chunk_fifo.push_back(c);
         if (left > 0) begin
            sector += SECTOR_W'(len);
            access_cnt++;
         end
      end
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] expected,
                                         input logic [31:0] actual);
      if (expected !== actual) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expected, actual);
         mismatches++;
      end
   endfunction

   task automatic queue_request(input logic op, input logic [SECTOR_W-1:0] start,
                                input logic [LEFT_W-1:0] count);
      request_fifo.push_back('{op, start, count});
      req_queued++;
   endtask

   // Waits until every queued request is taken and its chunks are back, then lets the block settle.
   task automatic drain();
      do @(posedge clock); while (req_taken != req_queued || chunk_fifo.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_slot_limit(input logic [SLOTS_CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_slots_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      slot_limit = value;
      limits_used++;
   endtask

   // Request driver: holds a stalled transfer, otherwise presents the next queued request
   // after a random gap.
   always @(posedge clock) begin
      request_type queued;
      int          roll;
      if (reset) begin
         req_valid <= 1'b0;
         sender_gap = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            split_request(req_operation, req_start_sector, req_sector_count);
            req_taken <= req_taken + 1;
            roll = $urandom_range(0, 99);
            sender_gap = (roll < 55) ? 0 : (roll < 90) ? $urandom_range(1, 3)
                                                       : $urandom_range(10, 40);
         end
         if (sender_gap > 0) begin
            sender_gap--;
            req_valid <= 1'b0;
         end else if (request_fifo.size() != 0) begin
            queued = request_fifo.pop_front();
            req_valid <= 1'b1;
            req_operation <= queued.op;
            req_start_sector <= queued.start;
            req_sector_count <= queued.count;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result backpressure: random runs of stall and flow, plus one long hold-off that lets the
   // block fill up while requests keep coming.
   always @(posedge clock) begin
      int roll;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else if (!hold_done && req_taken == HOLD_AT) begin
         hold_done = 1'b1;
         rsp_stall <= 1'b1;
         stall_run = LONG_HOLD;
      end else if (stall_run > 0) begin
         stall_run--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            rsp_stall <= 1'b1;
            stall_run = (roll < 32) ? $urandom_range(0, 2) : $urandom_range(10, 30);
         end else begin
            rsp_stall <= 1'b0;
            stall_run = (roll < 92) ? $urandom_range(0, 6) : $urandom_range(40, 100);
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      chunk_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (chunk_fifo.size() == 0) begin
            $error("result transfer with no chunk outstanding: slot %0d base 0x%0h",
                   rsp_slot, rsp_block_base);
            mismatches++;
         end else begin
            want = chunk_fifo.pop_front();
            compare_field("slot", 32'(want.slot), 32'(rsp_slot));
            compare_field("miss", 32'(want.miss), 32'(rsp_miss));
            compare_field("block_base", want.base, rsp_block_base);
            compare_field("offset_in_block", 32'(want.offset), 32'(rsp_offset_in_block));
            compare_field("chunk_length", 32'(want.length), 32'(rsp_chunk_length));
            compare_field("is_write", 32'(want.is_write), 32'(rsp_is_write));
            compare_field("last", 32'(want.last), 32'(rsp_last));
            chunks_checked++;
            if (want.miss) misses_seen++;
         end
      end
   end

   initial begin
      logic [SLOTS_CFG_W-1:0] phase_limit [4];
      int                     pool_blocks [4];
      logic [SECTOR_W-1:0]    pool_base;
      request_type            rq;
      int                     roll;
      phase_limit = '{SLOTS_CFG_W'(16), SLOTS_CFG_W'(4), SLOTS_CFG_W'(17), SLOTS_CFG_W'(2)};
      pool_blocks = '{24, 6, 20, 3};
      foreach (tag_mem[i]) tag_mem[i] = '0;
      foreach (stamp_mem[i]) stamp_mem[i] = '0;
      alloc_cnt = 0;
      access_cnt = '0;
      slot_limit = SLOTS_CFG_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, block crossings, sector wrap, zero and oversized counts.
      @(negedge clock);
      queue_request(1'b0, 32'h0, 11'd1);
      queue_request(1'b1, 32'h0, 11'd1);
      queue_request(1'b0, 32'd63, 11'd2);
      queue_request(1'b0, 32'hFFFF_FFFF, 11'd2);
      queue_request(1'b1, 32'd5, 11'd1024);
      queue_request(1'b0, 32'h0, 11'd0);
      queue_request(1'b0, 32'd100, 11'd2047);
      queue_request(1'b1, 32'hAAAA_AAAA, 11'h555);
      queue_request(1'b0, 32'h5555_5555, 11'h2AA);
      queue_request(1'b1, 32'd128, 11'd64);
      drain();

      // A single slot: every new block evicts the previous one.
      write_slot_limit(SLOTS_CFG_W'(1));
      @(negedge clock);
      queue_request(1'b0, 32'h0, 11'd1);
      queue_request(1'b0, 32'd64, 11'd1);
      queue_request(1'b0, 32'h0, 11'd1);
      drain();

      // Zero acts as one slot, an oversized value as the full slot count.
      write_slot_limit(SLOTS_CFG_W'(0));
      @(negedge clock);
      queue_request(1'b1, 32'd128, 11'd70);
      drain();
      write_slot_limit(SLOTS_CFG_W'(31));
      @(negedge clock);
      queue_request(1'b0, 32'h0, 11'd1);
      queue_request(1'b1, 32'h1234_5678, 11'd3);

      // Random phases: mostly reuse of a small working set of blocks so that hits, evictions
      // and lowered limits all occur, with some scattered sectors and odd counts.
      for (int p = 0; p < 4; p++) begin
         drain();
         write_slot_limit(phase_limit[p]);
         pool_base = $urandom & ~32'(SECTORS_PER_BLOCK - 1);
         @(negedge clock);
         for (int k = 0; k < 24; k++) begin
            rq.op = 1'($urandom_range(0, 1));
            roll = $urandom_range(0, 99);
            if (roll < 30) rq.start = $urandom;
            else rq.start = pool_base
                  + 32'(SECTORS_PER_BLOCK) * $urandom_range(0, pool_blocks[p] - 1)
                  + $urandom_range(0, SECTORS_PER_BLOCK - 1);
            roll = $urandom_range(0, 99);
            if (roll < 5) rq.count = '0;
            else if (roll < 13) rq.count = LEFT_W'($urandom_range(MAX_REQUEST + 1, 2047));
            else if (roll < 23) rq.count = LEFT_W'($urandom_range(129, MAX_REQUEST));
            else rq.count = LEFT_W'($urandom_range(1, 128));
            queue_request(rq.op, rq.start, rq.count);
         end
      end
      drain();

      $display("Sent %0d requests under %0d slot-limit settings; checked %0d chunks, %0d misses.",
               req_taken, limits_used, chunks_checked, misses_seen);
      $display("Result channel held off for %0d cycles once while requests kept arriving.",
               LONG_HOLD);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("FAIL");
      $finish;
   end

endmodule
